### hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
// Every check runs on the rising edge of clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition on every clock edge.
`define BIA_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check the consequent in the same cycle as the antecedent.
`define BIA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check the consequent in the cycle after the antecedent.
`define BIA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/bia_pkg.sv
package bia_pkg;

    // Pool geometry
    localparam int ID_COUNT   = 4096;
    localparam int WORD_BITS  = 32;
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int WORD_COUNT = (ID_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int WIDX_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;

    // Field widths
    localparam int ID_W  = 12;
    localparam int LIM_W = 13;
    localparam int ST_W  = 2;

    localparam logic [LIM_W-1:0] ID_COUNT_LIM = LIM_W'(ID_COUNT);
    localparam logic [LIM_W-1:0] LIMIT_RESET  = LIM_W'(4096);

    // Commands
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

    typedef logic [WORD_BITS-1:0] word_t;

    typedef struct packed {
        logic            command;
        logic [ID_W-1:0] id_value;
    } in_item_t;

    typedef struct packed {
        logic [ID_W-1:0] result_id;
        logic [ST_W-1:0] status;
    } out_item_t;

    // Search result of the head unit for the word now at the head of the ring
    typedef struct packed {
        logic             hit;
        logic [BIT_W-1:0] bit_idx;
    } head_res_t;

endpackage

### hw/rtl/bia_cell.sv
module bia_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           shift_en,
    input  bia_pkg::word_t word_in,
    output bia_pkg::word_t word_out
);

    bia_pkg::word_t word_reg;
    bia_pkg::word_t word_next;

    // Take the neighbor's word on each ring step, hold otherwise
    assign word_next = shift_en ? word_in : word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg <= '0;
        end
        else
        begin
            word_reg <= word_next;
        end
    end

    assign word_out = word_reg;

endmodule

### hw/rtl/bia_head.sv
module bia_head (
    input  bia_pkg::word_t                   word_in,
    input  logic [bia_pkg::WIDX_W-1:0]       word_idx,
    input  logic [bia_pkg::LIM_W-1:0]        lim,
    input  logic                             command,
    input  logic [bia_pkg::ID_W-1:0]         id_value,
    input  logic                             range_ok,
    input  logic                             already_found,
    output bia_pkg::head_res_t               res,
    output bia_pkg::word_t                   word_out
);

    localparam int HI_W = bia_pkg::LIM_W - bia_pkg::BIT_W;

    logic [HI_W-1:0]  lim_hi;
    logic [HI_W-1:0]  idx_ext;
    bia_pkg::word_t   in_limit;
    bia_pkg::word_t   avail;
    logic [bia_pkg::BIT_W-1:0] pick;
    logic             free_hit;

    function automatic logic [bia_pkg::BIT_W-1:0] BIT_W_CMP(input int b);
        BIT_W_CMP = bia_pkg::BIT_W'(b);
    endfunction

    assign lim_hi  = lim[bia_pkg::LIM_W-1:bia_pkg::BIT_W];
    assign idx_ext = HI_W'(word_idx);

    // Mask the bits of this word whose identifier is below the limit
    always_comb
    begin
        for (int b = 0; b < bia_pkg::WORD_BITS; b++)
        begin
            if (lim_hi > idx_ext)
            begin
                in_limit[b] = 1'b1;
            end
            else if (lim_hi == idx_ext)
            begin
                in_limit[b] = (BIT_W_CMP(b) < lim[bia_pkg::BIT_W-1:0]);
            end
            else
            begin
                in_limit[b] = 1'b0;
            end
        end
    end

    assign avail = ~word_in & in_limit;

    // Find the lowest free bit
    always_comb
    begin
        pick = '0;
        for (int b = bia_pkg::WORD_BITS - 1; b >= 0; b--)
        begin
            if (avail[b])
            begin
                pick = bia_pkg::BIT_W'(b);
            end
        end
    end

    assign res.hit     = (command == bia_pkg::CMD_ALLOC) && !already_found && (|avail);
    assign res.bit_idx = pick;

    assign free_hit = (command == bia_pkg::CMD_FREE) && range_ok
                      && (id_value[bia_pkg::ID_W-1:bia_pkg::BIT_W] ==
                          (bia_pkg::ID_W - bia_pkg::BIT_W)'(word_idx));

    // Set the allocated bit or clear the freed bit
    always_comb
    begin
        for (int b = 0; b < bia_pkg::WORD_BITS; b++)
        begin
            if (res.hit && (pick == bia_pkg::BIT_W'(b)))
            begin
                word_out[b] = 1'b1;
            end
            else if (free_hit && (id_value[bia_pkg::BIT_W-1:0] == bia_pkg::BIT_W'(b)))
            begin
                word_out[b] = 1'b0;
            end
            else
            begin
                word_out[b] = word_in[b];
            end
        end
    end

endmodule

### hw/rtl/bitmap_id_allocator.sv
// Channel  Direction  Handshake            Payload
// in       input      in_valid/in_ready    in_item   (command, id_value)
// out      output     out_valid/out_ready  out_item  (result_id, status)
// cfg      input      cfg_we, no wait      cfg_data  (id_limit)
//
// Each item makes one pass of the bitmap around the ring of word cells, one word passing
// the head unit a cycle while the ring is not held for a result not yet taken.
// The next item is accepted in the cycle after the result is registered.
// A result not yet taken holds the ring on its last step until out_ready.
// Reset clears the whole bitmap at once and sets id_limit to 4096.
`include "assert_macros.svh"

module bitmap_id_allocator (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  bia_pkg::in_item_t              in_item,
    output logic                           out_valid,
    input  logic                           out_ready,
    output bia_pkg::out_item_t             out_item,
    input  logic                           cfg_we,
    input  logic [bia_pkg::LIM_W-1:0]      cfg_data
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;
    localparam logic [bia_pkg::WIDX_W-1:0] LAST_WORD = bia_pkg::WIDX_W'(bia_pkg::WORD_COUNT - 1);

    logic                          state_reg, state_next;
    logic [bia_pkg::WIDX_W-1:0]    widx_reg, widx_next;
    logic [bia_pkg::LIM_W-1:0]     id_limit_reg, id_limit_next;
    logic [bia_pkg::LIM_W-1:0]     lim_reg, lim_next;
    logic                          cmd_reg, cmd_next;
    logic [bia_pkg::ID_W-1:0]      idv_reg, idv_next;
    logic                          range_ok_reg, range_ok_next;
    logic                          found_reg, found_next;
    logic [bia_pkg::ID_W-1:0]      found_id_reg, found_id_next;
    logic                          out_valid_reg, out_valid_next;
    bia_pkg::out_item_t            out_item_reg, out_item_next;

    logic [bia_pkg::LIM_W-1:0]     eff_lim;
    logic                          accept;
    logic                          last_step;
    logic                          shift_en;
    bia_pkg::head_res_t            head_res;
    bia_pkg::word_t                head_word;
    bia_pkg::word_t                head_new;
    bia_pkg::word_t                ring [bia_pkg::WORD_COUNT];
    logic                          fin_found;
    logic [bia_pkg::ID_W-1:0]      fin_id;

    // Ring of word cells; cell 0 is at the head, its update re-enters at the tail
    genvar gi;
    generate
        for (gi = 0; gi < bia_pkg::WORD_COUNT; gi++)
        begin : g_cell
            if (gi == bia_pkg::WORD_COUNT - 1)
            begin : g_tail
                bia_cell u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .shift_en (shift_en),
                    .word_in  (head_new),
                    .word_out (ring[gi])
                );
            end
            else
            begin : g_body
                bia_cell u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .shift_en (shift_en),
                    .word_in  (ring[gi+1]),
                    .word_out (ring[gi])
                );
            end
        end
    endgenerate

    assign head_word = ring[0];

    bia_head u_head (
        .word_in       (head_word),
        .word_idx      (widx_reg),
        .lim           (lim_reg),
        .command       (cmd_reg),
        .id_value      (idv_reg),
        .range_ok      (range_ok_reg),
        .already_found (found_reg),
        .res           (head_res),
        .word_out      (head_new)
    );

    // Saturate the limit to the pool size
    assign eff_lim = (id_limit_reg > bia_pkg::ID_COUNT_LIM) ? bia_pkg::ID_COUNT_LIM
                                                           : id_limit_reg;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign last_step = (state_reg == S_RUN) && (widx_reg == LAST_WORD);
    assign shift_en  = (state_reg == S_RUN) && !(last_step && out_valid_reg && !out_ready);

    assign fin_found = found_reg || head_res.hit;
    assign fin_id    = found_reg ? found_id_reg : {widx_reg, head_res.bit_idx};

    // Sequence one item around the ring and build its result
    always_comb
    begin
        state_next     = state_reg;
        widx_next      = widx_reg;
        lim_next       = lim_reg;
        cmd_next       = cmd_reg;
        idv_next       = idv_reg;
        range_ok_next  = range_ok_reg;
        found_next     = found_reg;
        found_id_next  = found_id_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        id_limit_next  = cfg_we ? cfg_data : id_limit_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next    = S_RUN;
                    widx_next     = '0;
                    lim_next      = eff_lim;
                    cmd_next      = in_item.command;
                    idv_next      = in_item.id_value;
                    range_ok_next = ({1'b0, in_item.id_value} < eff_lim);
                    found_next    = 1'b0;
                end
            end
            S_RUN:
            begin
                if (shift_en)
                begin
                    if (head_res.hit)
                    begin
                        found_next    = 1'b1;
                        found_id_next = {widx_reg, head_res.bit_idx};
                    end
                    if (last_step)
                    begin
                        state_next     = S_IDLE;
                        widx_next      = '0;
                        found_next     = 1'b0;
                        out_valid_next = 1'b1;
                        if (cmd_reg == bia_pkg::CMD_ALLOC)
                        begin
                            out_item_next.result_id = fin_found ? fin_id : '0;
                            out_item_next.status    = fin_found ? bia_pkg::ST_OK
                                                                : bia_pkg::ST_FULL;
                        end
                        else
                        begin
                            out_item_next.result_id = range_ok_reg ? idv_reg : '0;
                            out_item_next.status    = range_ok_reg ? bia_pkg::ST_OK
                                                                   : bia_pkg::ST_RANGE;
                        end
                    end
                    else
                    begin
                        widx_next = widx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            widx_reg      <= '0;
            id_limit_reg  <= bia_pkg::LIMIT_RESET;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            widx_reg      <= widx_next;
            id_limit_reg  <= id_limit_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        lim_reg      <= lim_next;
        cmd_reg      <= cmd_next;
        idv_reg      <= idv_next;
        range_ok_reg <= range_ok_next;
        found_id_reg <= found_id_next;
        out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    `BIA_ASSERT_NXT(a_accept_starts_run, accept, (state_reg == S_RUN) && (widx_reg == '0), "accepted item did not start a ring pass")
    `BIA_ASSERT_IMP(a_idle_index_zero, state_reg == S_IDLE, (widx_reg == '0) && !found_reg, "word index or found flag left over in idle")
    `BIA_ASSERT_IMP(a_found_only_alloc, found_reg, cmd_reg == bia_pkg::CMD_ALLOC, "found flag set for a free item")
    `BIA_ASSERT_IMP(a_error_zero_id, out_valid_reg && (out_item_reg.status != bia_pkg::ST_OK), out_item_reg.result_id == '0, "nonzero identifier with error status")
    `BIA_ASSERT_IMP(a_status_code, out_valid_reg, (out_item_reg.status == bia_pkg::ST_OK) || (out_item_reg.status == bia_pkg::ST_FULL) || (out_item_reg.status == bia_pkg::ST_RANGE), "undefined status code")

endmodule
